>>> rtl/core/het_pkg.sv
// Shared types and constants for the heading error pipeline.
// Q3.12 angle constants, datapath widths, CORDIC angle table.
// No dependencies.
package het_pkg;

	localparam int HW = 15;
	localparam int PW = 16;
	localparam int DW = PW + 1;
	localparam int PRE_SH = 8;
	localparam int CW = 28;
	localparam int ZW = 16;
	localparam int EW = 17;
	localparam int MAX_STAGES = 24;

	localparam logic signed [ZW-1:0] PI_Z = 16'sd12868;
	localparam logic signed [EW-1:0] PI_E = 17'sd12868;
	localparam logic signed [EW-1:0] TWO_PI_E = 17'sd25736;
	localparam logic signed [EW-1:0] THREE_PI_E = 17'sd38604;
	localparam logic signed [EW-1:0] FOUR_PI_E = 17'sd51472;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 op;
		logic signed [HW-1:0] heading;
		logic                 zero;
	} cordic_t;

	// round(atan(2^-i) * 4096)
	function automatic logic signed [ZW-1:0] atan_q12(input int unsigned idx);
		case (idx)
			0: return 16'sd3217;
			1: return 16'sd1899;
			2: return 16'sd1003;
			3: return 16'sd509;
			4: return 16'sd256;
			5: return 16'sd128;
			6: return 16'sd64;
			7: return 16'sd32;
			8: return 16'sd16;
			9: return 16'sd8;
			10: return 16'sd4;
			11: return 16'sd2;
			12: return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

endpackage

>>> rtl/core/het_prep.sv
// Front stage: position deltas, half-plane fold and CORDIC seed.
// Uses het_pkg.
module het_prep (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               op,
	input  logic signed [het_pkg::HW-1:0]      heading,
	input  logic signed [het_pkg::PW-1:0]      cur_x,
	input  logic signed [het_pkg::PW-1:0]      cur_y,
	input  logic signed [het_pkg::PW-1:0]      target_x,
	input  logic signed [het_pkg::PW-1:0]      target_y,
	output logic                               out_valid,
	output het_pkg::cordic_t                   out_data
);

	localparam int DW = het_pkg::DW;
	localparam int CW = het_pkg::CW;
	localparam int SH = het_pkg::PRE_SH;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] dxa;
	logic signed [DW-1:0] dya;
	logic                 neg;
	het_pkg::cordic_t     seed;
	logic                 valid_s1;
	het_pkg::cordic_t     data_s1;

	always_comb begin
		dx = DW'(target_x) - DW'(cur_x);
		dy = DW'(target_y) - DW'(cur_y);
		neg = dx[DW-1];
		dxa = neg ? -dx : dx;
		dya = neg ? -dy : dy;
		seed.x = {{(CW-DW-SH){dxa[DW-1]}}, dxa, {SH{1'b0}}};
		seed.y = {{(CW-DW-SH){dya[DW-1]}}, dya, {SH{1'b0}}};
		if (!neg) begin
			seed.z = '0;
		end else if (dy[DW-1]) begin
			seed.z = -het_pkg::PI_Z;
		end else begin
			seed.z = het_pkg::PI_Z;
		end
		seed.op = op;
		seed.heading = heading;
		seed.zero = (dx == '0) && (dy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= seed;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> rtl/core/het_cordic_stage.sv
// One registered CORDIC vectoring iteration.
// Uses het_pkg (cordic_t, atan_q12).
module het_cordic_stage #(
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  het_pkg::cordic_t in_data,
	output logic             out_valid,
	output het_pkg::cordic_t out_data
);

	localparam logic signed [het_pkg::ZW-1:0] ANG = het_pkg::atan_q12(STAGE);

	logic signed [het_pkg::CW-1:0] xs;
	logic signed [het_pkg::CW-1:0] ys;
	het_pkg::cordic_t              nxt;
	logic                          valid_s1;
	het_pkg::cordic_t              data_s1;

	always_comb begin
		xs = in_data.x >>> STAGE;
		ys = in_data.y >>> STAGE;
		nxt = in_data;
		if (in_data.y > 0) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ANG;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> rtl/core/het_wrap.sv
// Back end: bearing minus heading (plus pi in reverse), then wrap to (-pi, pi].
// Two register stages. Uses het_pkg.
module het_wrap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  het_pkg::cordic_t              in_data,
	output logic                          out_valid,
	output logic signed [het_pkg::HW-1:0] heading_error
);

	localparam int EW = het_pkg::EW;
	localparam int HW = het_pkg::HW;

	logic signed [het_pkg::ZW-1:0] bearing;
	logic signed [EW-1:0]          e_raw;
	logic signed [EW-1:0]          e_s1;
	logic                          valid_s1;
	logic signed [EW-1:0]          w;
	logic signed [HW-1:0]          err_s2;
	logic                          valid_s2;

	always_comb begin
		bearing = in_data.zero ? '0 : in_data.z;
		e_raw = EW'(bearing) - EW'(in_data.heading);
		if (in_data.op) begin
			e_raw = e_raw + het_pkg::PI_E;
		end
	end

	// sum stays within (-5pi, 5pi): at most two turns of correction
	always_comb begin
		if (e_s1 > het_pkg::THREE_PI_E) begin
			w = e_s1 - het_pkg::FOUR_PI_E;
		end else if (e_s1 > het_pkg::PI_E) begin
			w = e_s1 - het_pkg::TWO_PI_E;
		end else if (e_s1 <= -het_pkg::THREE_PI_E) begin
			w = e_s1 + het_pkg::FOUR_PI_E;
		end else if (e_s1 <= -het_pkg::PI_E) begin
			w = e_s1 + het_pkg::TWO_PI_E;
		end else begin
			w = e_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		e_s1   <= e_raw;
		err_s2 <= w[HW-1:0];
	end

	assign out_valid     = valid_s2;
	assign heading_error = err_s2;

endmodule

>>> rtl/core/heading_error_to_target_unit.sv
// Heading error toward a target: atan2 by pipelined CORDIC, heading subtract
// and wrap. Top level; uses het_pkg, het_prep, het_cordic_stage, het_wrap.
//
// A request is taken in every cycle that start is high; busy is never raised.
// Each request yields one result, marked by done for one cycle, after it
// passes one seed stage, one stage per CORDIC iteration and two stages for
// subtract and wrap; results come out in request order. The latency grows
// with the length of the unrolled CORDIC chain.
// CORDIC_STAGES runs from 8 to 24; larger values act as 24.
module heading_error_to_target_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic signed [het_pkg::HW-1:0] heading,
	input  logic signed [het_pkg::PW-1:0] cur_x,
	input  logic signed [het_pkg::PW-1:0] cur_y,
	input  logic signed [het_pkg::PW-1:0] target_x,
	input  logic signed [het_pkg::PW-1:0] target_y,
	output logic                          done,
	output logic signed [het_pkg::HW-1:0] heading_error
);

	localparam int N = (CORDIC_STAGES > het_pkg::MAX_STAGES) ?
		het_pkg::MAX_STAGES : CORDIC_STAGES;
	localparam int LAT = N + 3;

	logic             pipe_valid [0:N];
	het_pkg::cordic_t pipe_data  [0:N];

	assign busy = 1'b0;

	het_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.op        (op),
		.heading   (heading),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.target_x  (target_x),
		.target_y  (target_y),
		.out_valid (pipe_valid[0]),
		.out_data  (pipe_data[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cordic
		het_cordic_stage #(
			.STAGE (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pipe_valid[i]),
			.in_data   (pipe_data[i]),
			.out_valid (pipe_valid[i+1]),
			.out_data  (pipe_data[i+1])
		);
	end

	het_wrap u_wrap (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (pipe_valid[N]),
		.in_data       (pipe_data[N]),
		.out_valid     (done),
		.heading_error (heading_error)
	);

`ifndef SYNTHESIS
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading_error > -het_pkg::PI_Z) && (heading_error <= het_pkg::PI_Z))
		else $error("heading_error outside (-pi, pi]");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request did not complete after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without matching request");
`endif

endmodule
